### design/otat_pkg.sv
// Shared types and codes for the owner-tagged allocation tracker.
package otat_pkg;

   typedef enum logic [1:0] {
      OP_TRACK   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_STORED   = 3'd0,
      ST_FULL     = 3'd1,
      ST_FREED    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_RELEASED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CLOSE
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [15:0] pages;
      logic [7:0]  owner;
   } entry_type;

   typedef struct packed {
      logic hit;   // entry at the head was changed
      logic grow;  // change adds an entry
      logic emit;  // change produces a released-entry beat
   } head_result_type;

endpackage

### design/owner_tagged_allocation_tracker.sv
// Top level: request control, entry chain and result register of the tracker.
// Each request rotates the whole chain once past the head unit, then loads a closing beat;
// a stalled result beat holds the scan.
// One request is in work at a time; a new one is taken once the closing beat is loaded.
// Reset clears all valid marks and the active count at once; no clearing sweep.
module owner_tagged_allocation_tracker
   import otat_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_base_addr,
   input  logic [15:0] req_page_count,
   input  logic [7:0]  req_owner_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_released_addr,
   output logic [15:0] rsp_released_pages,
   output logic [5:0]  rsp_active_entries,
   output logic        rsp_last
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   state_type       state_ff, state_in;
   logic [IW-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0]   live_count_ff, live_count_in;
   logic            found_ff, found_in;
   logic [1:0]      op_ff;
   logic [31:0]     addr_ff;
   logic [15:0]     pages_ff;
   logic [7:0]      owner_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [31:0]     rsp_addr_ff, rsp_addr_in;
   logic [15:0]     rsp_pages_ff, rsp_pages_in;
   logic [5:0]      rsp_active_ff, rsp_active_in;
   logic            rsp_last_ff, rsp_last_in;

   entry_type       chain [TABLE_DEPTH];
   entry_type       tail_entry;
   head_result_type head_res;
   logic            out_free, step, accept, close, load;
   status_type      close_status;
   logic [CW+5:0]   active_ext;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = (state_ff == S_SCAN) && out_free;
   assign close    = (state_ff == S_CLOSE) && out_free;
   assign accept   = req_valid && req_ready;
   assign load     = (step && head_res.emit) || close;

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      entry_type cell_in;
      if (k == TABLE_DEPTH - 1) begin : g_tail
         assign cell_in = tail_entry;
      end else begin : g_body
         assign cell_in = chain[k+1];
      end
      otat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (step),
         .entry_in (cell_in),
         .entry_out(chain[k])
      );
   end

   otat_head u_head (
      .op        (op_ff),
      .addr      (addr_ff),
      .pages     (pages_ff),
      .owner     (owner_ff),
      .found     (found_ff),
      .head_entry(chain[0]),
      .tail_entry(tail_entry),
      .result    (head_res)
   );

   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_SCAN;
               scan_cnt_in = '0;
            end
         end
         S_SCAN: begin
            if (step) begin
               if (scan_cnt_ff == IW'(TABLE_DEPTH - 1)) begin
                  state_in    = S_CLOSE;
                  scan_cnt_in = '0;
               end else begin
                  scan_cnt_in = scan_cnt_ff + IW'(1);
               end
            end
         end
         S_CLOSE: begin
            if (close) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      found_in      = found_ff;
      live_count_in = live_count_ff;
      if (accept) begin
         found_in = 1'b0;
      end else if (step && head_res.hit) begin
         found_in = 1'b1;
         if (head_res.grow) begin
            live_count_in = live_count_ff + CW'(1);
         end else begin
            live_count_in = live_count_ff - CW'(1);
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_TRACK:   close_status = found_ff ? ST_STORED : ST_FULL;
         OP_FREE:    close_status = found_ff ? ST_FREED : ST_NOTFOUND;
         OP_RELEASE: close_status = found_ff ? ST_FREED : ST_NOTFOUND;
         default:    close_status = ST_NOTFOUND;
      endcase
   end

   assign active_ext = {6'd0, live_count_in};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_active_in = rsp_active_ff;
      rsp_last_in   = rsp_last_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_active_in = active_ext[5:0];
         if (close) begin
            rsp_status_in = close_status;
            rsp_addr_in   = '0;
            rsp_pages_in  = '0;
            rsp_last_in   = 1'b1;
         end else begin
            rsp_status_in = ST_RELEASED;
            rsp_addr_in   = chain[0].addr;
            rsp_pages_in  = chain[0].pages;
            rsp_last_in   = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_cnt_ff   <= '0;
         live_count_ff <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         live_count_ff <= live_count_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_type;
         addr_ff  <= req_base_addr;
         pages_ff <= req_page_count;
         owner_ff <= req_owner_id;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_active_ff <= rsp_active_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_released_addr  = rsp_addr_ff;
   assign rsp_released_pages = rsp_pages_ff;
   assign rsp_active_entries = rsp_active_ff;
   assign rsp_last           = rsp_last_ff;

   // hold the rotation while the result register is blocked
   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !out_free) |=> $stable(scan_cnt_ff))
      else $error("scan advanced while result register was blocked");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= TABLE_DEPTH)
      else $error("active count exceeds table depth");

   a_release_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_RELEASED) |-> !rsp_last)
      else $error("released-entry beat marked last");

   a_idle_counter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (scan_cnt_ff == '0))
      else $error("scan counter not parked while idle");

endmodule

### design/otat_cell.sv
// One table slot of the rotating entry chain.
module otat_cell
   import otat_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift_en,
   input  entry_type entry_in,
   output entry_type entry_out
);

   logic        valid_ff;
   logic [31:0] addr_ff;
   logic [15:0] pages_ff;
   logic [7:0]  owner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         addr_ff  <= entry_in.addr;
         pages_ff <= entry_in.pages;
         owner_ff <= entry_in.owner;
      end
   end

   assign entry_out = '{valid: valid_ff, addr: addr_ff, pages: pages_ff, owner: owner_ff};

endmodule

### design/otat_head.sv
// Compare and update unit at the head of the entry chain.
module otat_head
   import otat_pkg::*;
(
   input  logic [1:0]      op,
   input  logic [31:0]     addr,
   input  logic [15:0]     pages,
   input  logic [7:0]      owner,
   input  logic            found,
   input  entry_type       head_entry,
   output entry_type       tail_entry,
   output head_result_type result
);

   always_comb begin
      tail_entry = head_entry;
      result     = '0;
      unique case (op)
         OP_TRACK: begin
            // take the first free slot only
            if (!found && !head_entry.valid) begin
               tail_entry.valid = 1'b1;
               tail_entry.addr  = addr;
               tail_entry.pages = pages;
               tail_entry.owner = owner;
               result.hit       = 1'b1;
               result.grow      = 1'b1;
            end
         end
         OP_FREE: begin
            if (!found && head_entry.valid && head_entry.addr == addr &&
                head_entry.pages == pages) begin
               tail_entry.valid = 1'b0;
               result.hit       = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (head_entry.valid && head_entry.owner == owner) begin
               tail_entry.valid = 1'b0;
               result.hit       = 1'b1;
               result.emit      = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule
